FILE: hw/rtl/wia_pkg.sv
package wia_pkg;

    // Widths fixed by the item and register fields
    localparam int SOURCES_DEF = 4;
    localparam int SRC_IN      = 4;
    localparam int PAYLOAD_W   = 24;
    localparam int COUNTER_W   = 10;
    localparam int TOTAL_W     = 6;
    localparam int WEIGHT_W    = 4;
    localparam int PERIOD_W    = 6;
    localparam int WINNER_W    = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 6;
    localparam int QUEUE_DEPTH = 2;

    // Source slots
    localparam int SRC_AUDIO  = 0;
    localparam int SRC_VIDEO  = 1;
    localparam int SRC_MOTION = 2;
    localparam int SRC_JPEG   = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_AUDIO   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_VIDEO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_MOTION  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_JPEG    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVICE_PERIOD = 3'd4;

    // Register reset values
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_AUDIO  = 4'd1;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_OTHER  = 4'd3;
    localparam logic [PERIOD_W-1:0] RST_PERIOD        = 6'd30;

    typedef struct packed {
        logic [SRC_IN-1:0][WEIGHT_W-1:0] weight;
        logic [PERIOD_W-1:0]             period;
    } wia_cfg_t;

    // Classified command as it sits in the queue
    typedef struct packed {
        logic                             cmd_en;
        logic                             evt_en;
        logic                             accept;
        logic [SRC_IN-1:0]                eligible;
        logic [SRC_IN-1:0][PAYLOAD_W-1:0] load;
    } wia_entry_t;

    typedef struct packed {
        logic       push;
        wia_entry_t entry;
    } wia_q_wr_t;

    typedef struct packed {
        logic       valid;
        logic       full;
        wia_entry_t entry;
    } wia_q_rd_t;

endpackage

FILE: hw/rtl/wia_if.sv
interface wia_cmd_if;
    import wia_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 command_irq_enable;
    logic                 event_irq_enable;
    logic                 audio_ready;
    logic [PAYLOAD_W-1:0] audio_size;
    logic                 video_ready;
    logic [PAYLOAD_W-1:0] video_size;
    logic                 motion_on;
    logic [PAYLOAD_W-1:0] motion_count;
    logic                 jpeg_ready;
    logic [PAYLOAD_W-1:0] jpeg_size;
    logic                 host_accepts;

    modport source (
        output valid, command_irq_enable, event_irq_enable, audio_ready, audio_size,
               video_ready, video_size, motion_on, motion_count, jpeg_ready, jpeg_size,
               host_accepts,
        input  ready
    );
    modport sink (
        input  valid, command_irq_enable, event_irq_enable, audio_ready, audio_size,
               video_ready, video_size, motion_on, motion_count, jpeg_ready, jpeg_size,
               host_accepts,
        output ready
    );
endinterface

interface wia_irq_if;
    import wia_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 command_enabled;
    logic                 event_enabled;
    logic                 raised;
    logic [WINNER_W-1:0]  winner;
    logic [PAYLOAD_W-1:0] payload;

    modport source (
        output valid, command_enabled, event_enabled, raised, winner, payload,
        input  ready
    );
    modport sink (
        input  valid, command_enabled, event_enabled, raised, winner, payload,
        output ready
    );
endinterface

FILE: hw/rtl/wia_front.sv
module wia_front #(
    parameter int SOURCES = wia_pkg::SOURCES_DEF
) (
    wia_cmd_if.sink          cmd,
    input  logic             q_full,
    output wia_pkg::wia_q_wr_t q_wr
);
    import wia_pkg::*;

    logic [SRC_IN-1:0] raw_elig;

    // Classify each source's request
    assign raw_elig[SRC_AUDIO]  = cmd.audio_ready;
    assign raw_elig[SRC_VIDEO]  = cmd.video_ready;
    assign raw_elig[SRC_MOTION] = cmd.motion_on && (cmd.motion_count != '0);
    assign raw_elig[SRC_JPEG]   = cmd.jpeg_ready;

    // Drop sources that this build does not have
    for (genvar g = 0; g < SRC_IN; g++)
    begin : g_mask
        if (g < SOURCES)
        begin : g_on
            assign q_wr.entry.eligible[g] = raw_elig[g];
        end
        else
        begin : g_off
            assign q_wr.entry.eligible[g] = 1'b0;
        end
    end

    assign q_wr.entry.cmd_en            = cmd.command_irq_enable;
    assign q_wr.entry.evt_en            = cmd.event_irq_enable;
    assign q_wr.entry.accept            = cmd.host_accepts;
    assign q_wr.entry.load[SRC_AUDIO]   = cmd.audio_size;
    assign q_wr.entry.load[SRC_VIDEO]   = cmd.video_size;
    assign q_wr.entry.load[SRC_MOTION]  = cmd.motion_count;
    assign q_wr.entry.load[SRC_JPEG]    = cmd.jpeg_size;

    // Take an item whenever the queue has room
    assign cmd.ready = !q_full;
    assign q_wr.push = cmd.valid && !q_full;

endmodule

FILE: hw/rtl/wia_queue.sv
module wia_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  wia_pkg::wia_q_wr_t q_wr,
    input  logic               pop,
    output wia_pkg::wia_q_rd_t q_rd
);
    import wia_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    wia_entry_t       mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign do_push = q_wr.push && (count_reg != CNT_W'(QUEUE_DEPTH));
    assign do_pop  = pop && (count_reg != '0);

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed items
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= q_wr.entry;
        end
    end

    assign q_rd.valid = (count_reg != '0);
    assign q_rd.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_rd.entry = mem[rd_ptr_reg];

endmodule

FILE: hw/rtl/wia_back.sv
module wia_back #(
    parameter int SOURCES = wia_pkg::SOURCES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  wia_pkg::wia_cfg_t  cfg,
    input  wia_pkg::wia_q_rd_t q_rd,
    output logic               pop,
    wia_irq_if.source          irq
);
    import wia_pkg::*;

    localparam int IDX_W = $clog2(SOURCES);

    logic [COUNTER_W-1:0] cnt_reg [SOURCES];
    logic [COUNTER_W-1:0] cnt_next [SOURCES];
    logic [COUNTER_W-1:0] cnt_eff [SOURCES];
    logic [WEIGHT_W-1:0]  wt [SOURCES];
    logic [SOURCES-1:0]   elig;
    logic [TOTAL_W-1:0]   total_reg, total_next;

    logic                 out_valid_reg;
    logic                 cmd_en_reg, evt_en_reg, raised_reg;
    logic [WINNER_W-1:0]  winner_reg;
    logic [PAYLOAD_W-1:0] payload_reg;

    logic                 wipe;
    logic                 found;
    logic [IDX_W-1:0]     best;
    logic [COUNTER_W-1:0] best_cnt;
    logic                 raise;
    logic [PAYLOAD_W-1:0] win_load;

    // Take the next item while the output slot is free or being drained
    assign pop = q_rd.valid && (!out_valid_reg || irq.ready);

    // Period clear applies to every event-enabled command once the total reaches the period
    assign wipe = q_rd.entry.evt_en && (total_reg >= TOTAL_W'(cfg.period));

    for (genvar g = 0; g < SOURCES; g++)
    begin : g_src
        if (g < SRC_IN)
        begin : g_real
            assign elig[g] = q_rd.entry.eligible[g];
            assign wt[g]   = cfg.weight[g];
        end
        else
        begin : g_extra
            assign elig[g] = 1'b0;
            assign wt[g]   = '0;
        end
        assign cnt_eff[g]  = wipe ? '0 : cnt_reg[g];
        assign cnt_next[g] = (raise && (best == IDX_W'(g)))
                             ? cnt_eff[g] + COUNTER_W'(wt[g]) : cnt_eff[g];
    end

    // Pick the least served eligible source, lower index on ties
    always_comb
    begin
        found    = 1'b0;
        best     = '0;
        best_cnt = '0;
        for (int i = 0; i < SOURCES; i++)
        begin
            if (elig[i] && (!found || (cnt_eff[i] < best_cnt)))
            begin
                found    = 1'b1;
                best     = IDX_W'(i);
                best_cnt = cnt_eff[i];
            end
        end
    end

    assign raise = q_rd.entry.evt_en && found && q_rd.entry.accept;

    // Select the winner's payload
    always_comb
    begin
        win_load = '0;
        for (int i = 0; i < SRC_IN; i++)
        begin
            if (i == int'(best))
            begin
                win_load = q_rd.entry.load[i];
            end
        end
    end

    assign total_next = raise ? (wipe ? TOTAL_W'(1) : total_reg + 1'b1)
                              : (wipe ? '0 : total_reg);

    // Update service state per popped item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SOURCES; i++)
            begin
                cnt_reg[i] <= '0;
            end
            total_reg <= '0;
        end
        else if (pop)
        begin
            for (int i = 0; i < SOURCES; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
            total_reg <= total_next;
        end
    end

    // Hold the result until the host side takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (irq.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_en_reg  <= q_rd.entry.cmd_en;
            evt_en_reg  <= q_rd.entry.evt_en;
            raised_reg  <= raise;
            winner_reg  <= raise ? WINNER_W'(best) : '0;
            payload_reg <= raise ? win_load : '0;
        end
    end

    assign irq.valid           = out_valid_reg;
    assign irq.command_enabled = cmd_en_reg;
    assign irq.event_enabled   = evt_en_reg;
    assign irq.raised          = raised_reg;
    assign irq.winner          = winner_reg;
    assign irq.payload         = payload_reg;

endmodule

FILE: hw/rtl/weighted_interrupt_arbiter.sv
// Weighted least-served arbiter for one host interrupt line shared by audio,
// video, motion and JPEG sources. Each command item on cmd yields exactly one
// result item on irq, in order. The block takes one item per clock cycle while its
// queue has room: the front stage classifies the command into a two-entry queue,
// and the back stage runs the period clear, the minimum-counter pick and the
// counter update combinationally, ahead of the result register that offers the
// result on irq. Either side may stall freely; up to two commands plus one waiting
// result are buffered. Weights and the service period are written through
// cfg_we/cfg_index/cfg_data; the user must write them only while the block is idle,
// as the block itself does not enforce this.
module weighted_interrupt_arbiter #(
    parameter int SOURCES = wia_pkg::SOURCES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    wia_cmd_if.sink                      cmd,
    wia_irq_if.source                    irq,
    input  logic                         cfg_we,
    input  logic [wia_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wia_pkg::CFG_DATA_W-1:0] cfg_data
);
    import wia_pkg::*;

    wia_cfg_t  cfg_reg;
    wia_q_wr_t q_wr;
    wia_q_rd_t q_rd;
    logic      pop;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.weight[SRC_AUDIO]  <= RST_WEIGHT_AUDIO;
            cfg_reg.weight[SRC_VIDEO]  <= RST_WEIGHT_OTHER;
            cfg_reg.weight[SRC_MOTION] <= RST_WEIGHT_OTHER;
            cfg_reg.weight[SRC_JPEG]   <= RST_WEIGHT_OTHER;
            cfg_reg.period             <= RST_PERIOD;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WEIGHT_AUDIO:   cfg_reg.weight[SRC_AUDIO]  <= cfg_data[WEIGHT_W-1:0];
                CFG_WEIGHT_VIDEO:   cfg_reg.weight[SRC_VIDEO]  <= cfg_data[WEIGHT_W-1:0];
                CFG_WEIGHT_MOTION:  cfg_reg.weight[SRC_MOTION] <= cfg_data[WEIGHT_W-1:0];
                CFG_WEIGHT_JPEG:    cfg_reg.weight[SRC_JPEG]   <= cfg_data[WEIGHT_W-1:0];
                CFG_SERVICE_PERIOD: cfg_reg.period             <= cfg_data[PERIOD_W-1:0];
                default:            ;
            endcase
        end
    end

    wia_front #(
        .SOURCES(SOURCES)
    ) u_front (
        .cmd    (cmd),
        .q_full (q_rd.full),
        .q_wr   (q_wr)
    );

    wia_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .q_wr  (q_wr),
        .pop   (pop),
        .q_rd  (q_rd)
    );

    wia_back #(
        .SOURCES(SOURCES)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .q_rd  (q_rd),
        .pop   (pop),
        .irq   (irq)
    );

    // A raise only happens with event interrupts enabled
    a_raise_needs_event: assert property (@(posedge clk) disable iff (!rst_n)
        (irq.valid && irq.raised) |-> irq.event_enabled)
        else $error("interrupt raised with events disabled");

    // Without a raise the winner and payload read zero
    a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (irq.valid && !irq.raised) |-> ((irq.winner == '0) && (irq.payload == '0)))
        else $error("winner or payload set without a raise");

    // Motion wins only with a nonzero count
    a_motion_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (irq.valid && irq.raised && (irq.winner == WINNER_W'(SRC_MOTION)))
        |-> (irq.payload != '0))
        else $error("motion raised with zero count");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import wia_pkg::*;

    localparam int     BURST_MAX     = 40;
    localparam int     SQUEEZE_ITEMS = 24;
    localparam int     HOLD_CYCLES   = 120;
    localparam int     SETTLE_CYCLES = 4;
    localparam int     PHASE_ITEMS   = 185;
    localparam int     PHASES        = 6;
    localparam longint TIMEOUT_NS    = 64'd3_200_000;

    // Index past the register list; writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

    typedef struct packed {
        logic                 command_irq_enable;
        logic                 event_irq_enable;
        logic                 audio_ready;
        logic [PAYLOAD_W-1:0] audio_size;
        logic                 video_ready;
        logic [PAYLOAD_W-1:0] video_size;
        logic                 motion_on;
        logic [PAYLOAD_W-1:0] motion_count;
        logic                 jpeg_ready;
        logic [PAYLOAD_W-1:0] jpeg_size;
        logic                 host_accepts;
    } command_t;

    typedef struct packed {
        logic                 command_enabled;
        logic                 event_enabled;
        logic                 raised;
        logic [WINNER_W-1:0]  winner;
        logic [PAYLOAD_W-1:0] payload;
    } grant_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_COMB,
        RX_SPARSE
    } rx_style_t;

    // Least-served arbitration model and the queue of interrupts it predicts
    class irq_grant_book;
        logic [WEIGHT_W-1:0]  weight [SRC_IN];
        logic [PERIOD_W-1:0]  period;
        logic [COUNTER_W-1:0] served [SRC_IN];
        logic [TOTAL_W-1:0]   total;
        grant_t               pending_grants [$];
        int                   errors;
        int                   commands;
        int                   raises;

        function new();
            int i;
            for (i = 0; i < SRC_IN; i++)
            begin
                weight[i] = RST_WEIGHT_OTHER;
                served[i] = '0;
            end
            weight[SRC_AUDIO] = RST_WEIGHT_AUDIO;
            period   = RST_PERIOD;
            total    = '0;
            errors   = 0;
            commands = 0;
            raises   = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_WEIGHT_AUDIO:   weight[SRC_AUDIO]  = data[WEIGHT_W-1:0];
                CFG_WEIGHT_VIDEO:   weight[SRC_VIDEO]  = data[WEIGHT_W-1:0];
                CFG_WEIGHT_MOTION:  weight[SRC_MOTION] = data[WEIGHT_W-1:0];
                CFG_WEIGHT_JPEG:    weight[SRC_JPEG]   = data[WEIGHT_W-1:0];
                CFG_SERVICE_PERIOD: period             = data[PERIOD_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_command(command_t c);
            grant_t               g;
            logic                 eligible [SRC_IN];
            logic [PAYLOAD_W-1:0] load [SRC_IN];
            int                   best;
            int                   i;
            g = '0;
            g.command_enabled = c.command_irq_enable;
            g.event_enabled   = c.event_irq_enable;
            commands++;
            if (c.event_irq_enable)
            begin
                // Clear all counters once the served total reaches the period
                if (total >= period)
                begin
                    total = '0;
                    for (i = 0; i < SRC_IN; i++)
                        served[i] = '0;
                end
                eligible[SRC_AUDIO]  = c.audio_ready;
                load[SRC_AUDIO]      = c.audio_size;
                eligible[SRC_VIDEO]  = c.video_ready;
                load[SRC_VIDEO]      = c.video_size;
                eligible[SRC_MOTION] = c.motion_on && (c.motion_count != '0);
                load[SRC_MOTION]     = c.motion_count;
                eligible[SRC_JPEG]   = c.jpeg_ready;
                load[SRC_JPEG]       = c.jpeg_size;
                // Smallest counter wins, lower index on ties
                best = -1;
                for (i = 0; i < SRC_IN; i++)
                    if (eligible[i] && (best < 0 || served[i] < served[best]))
                        best = i;
                if (best >= 0 && c.host_accepts)
                begin
                    g.raised     = 1'b1;
                    g.winner     = best[WINNER_W-1:0];
                    g.payload    = load[best];
                    served[best] = served[best] + COUNTER_W'(weight[best]);
                    total        = total + 1'b1;
                    raises++;
                end
            end
            pending_grants.push_back(g);
        endfunction

        function void compare_field(string name, logic [PAYLOAD_W-1:0] want,
                                    logic [PAYLOAD_W-1:0] got);
            if (want !== got)
            begin
                $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_grant(grant_t got);
            grant_t want;
            if (pending_grants.size() == 0)
            begin
                $error("interrupt item with no command outstanding: %s %0d %0d 0x%0h",
                       "raised/winner/payload", got.raised, got.winner, got.payload);
                errors++;
                return;
            end
            want = pending_grants.pop_front();
            compare_field("command_enabled", PAYLOAD_W'(want.command_enabled),
                          PAYLOAD_W'(got.command_enabled));
            compare_field("event_enabled", PAYLOAD_W'(want.event_enabled),
                          PAYLOAD_W'(got.event_enabled));
            compare_field("raised", PAYLOAD_W'(want.raised), PAYLOAD_W'(got.raised));
            compare_field("winner", PAYLOAD_W'(want.winner), PAYLOAD_W'(got.winner));
            compare_field("payload", want.payload, got.payload);
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    hold_requests;
    int                    settings_applied;
    irq_grant_book         book;

    wia_cmd_if cmd_ch ();
    wia_irq_if irq_ch ();

    weighted_interrupt_arbiter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .irq       (irq_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Abort a run that hangs
    initial
    begin
        #(TIMEOUT_NS);
        $display("weighted_interrupt_arbiter verification failed");
        $finish;
    end

    // Interrupt side: check each accepted item, then choose the next ready
    initial
    begin
        grant_t    got;
        rx_style_t style;
        int        span;
        int        slot;
        int        comb;
        int        duty;
        int        hold_left;
        int        hold_seen;
        style     = RX_OPEN;
        span      = 32;
        slot      = 0;
        comb      = 2;
        duty      = 1;
        hold_left = 0;
        hold_seen = 0;
        irq_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && irq_ch.valid && irq_ch.ready)
            begin
                got.command_enabled = irq_ch.command_enabled;
                got.event_enabled   = irq_ch.event_enabled;
                got.raised          = irq_ch.raised;
                got.winner          = irq_ch.winner;
                got.payload         = irq_ch.payload;
                book.check_grant(got);
            end
            if (hold_seen != hold_requests)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                irq_ch.ready <= 1'b0;
            end
            else
            begin
                // Switch to a new stall style when the current span runs out
                slot++;
                if (slot >= span)
                begin
                    slot  = 0;
                    span  = $urandom_range(8, 96);
                    style = rx_style_t'($urandom_range(0, 3));
                    comb  = $urandom_range(2, 6);
                    duty  = $urandom_range(1, comb - 1);
                end
                case (style)
                    RX_OPEN:  irq_ch.ready <= 1'b1;
                    RX_COIN:  irq_ch.ready <= 1'($urandom_range(0, 1));
                    RX_COMB:  irq_ch.ready <= ((slot % comb) < duty);
                    default:  irq_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Offer one command item and hold it until accepted
    task automatic send_command(command_t c);
        cmd_ch.valid              <= 1'b1;
        cmd_ch.command_irq_enable <= c.command_irq_enable;
        cmd_ch.event_irq_enable   <= c.event_irq_enable;
        cmd_ch.audio_ready        <= c.audio_ready;
        cmd_ch.audio_size         <= c.audio_size;
        cmd_ch.video_ready        <= c.video_ready;
        cmd_ch.video_size         <= c.video_size;
        cmd_ch.motion_on          <= c.motion_on;
        cmd_ch.motion_count       <= c.motion_count;
        cmd_ch.jpeg_ready         <= c.jpeg_ready;
        cmd_ch.jpeg_size          <= c.jpeg_size;
        cmd_ch.host_accepts       <= c.host_accepts;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        book.note_command(c);
    endtask

    task automatic pause_sender(int cycles);
        if (cycles > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Drop valid and wait until every predicted interrupt has come back
    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        while (book.pending_grants.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        book.set_register(idx, data);
    endtask

    task automatic apply_setting(logic [CFG_DATA_W-1:0] wa, logic [CFG_DATA_W-1:0] wv,
                                 logic [CFG_DATA_W-1:0] wm, logic [CFG_DATA_W-1:0] wj,
                                 logic [CFG_DATA_W-1:0] per);
        write_register(CFG_WEIGHT_AUDIO, wa);
        write_register(CFG_WEIGHT_VIDEO, wv);
        write_register(CFG_WEIGHT_MOTION, wm);
        write_register(CFG_WEIGHT_JPEG, wj);
        write_register(CFG_SERVICE_PERIOD, per);
        cfg_we <= 1'b0;
        settings_applied++;
    endtask

    // Sizes lean toward zero, one and all-ones
    function automatic logic [PAYLOAD_W-1:0] pick_size();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return PAYLOAD_W'(1);
            default: return PAYLOAD_W'($urandom);
        endcase
    endfunction

    function automatic command_t random_command();
        command_t c;
        c.command_irq_enable = 1'($urandom_range(0, 1));
        c.event_irq_enable   = ($urandom_range(0, 9) != 0);
        c.audio_ready        = 1'($urandom_range(0, 1));
        c.audio_size         = pick_size();
        c.video_ready        = 1'($urandom_range(0, 1));
        c.video_size         = pick_size();
        c.motion_on          = 1'($urandom_range(0, 1));
        c.motion_count       = ($urandom_range(0, 3) == 0) ? '0 : pick_size();
        c.jpeg_ready         = 1'($urandom_range(0, 1));
        c.jpeg_size          = pick_size();
        c.host_accepts       = ($urandom_range(0, 4) != 0);
        return c;
    endfunction

    function automatic command_t build_command(logic cmd_en, logic evt_en, logic [SRC_IN-1:0] rdy,
                                               logic [PAYLOAD_W-1:0] base, logic accept);
        command_t c;
        c.command_irq_enable = cmd_en;
        c.event_irq_enable   = evt_en;
        c.audio_ready        = rdy[SRC_AUDIO];
        c.audio_size         = base;
        c.video_ready        = rdy[SRC_VIDEO];
        c.video_size         = base + PAYLOAD_W'(1);
        c.motion_on          = rdy[SRC_MOTION];
        c.motion_count       = base;
        c.jpeg_ready         = rdy[SRC_JPEG];
        c.jpeg_size          = base ^ 24'h5A5A5A;
        c.host_accepts       = accept;
        return c;
    endfunction

    // Random traffic in bursts; optionally stall the result side or drain mid-phase
    task automatic run_phase(int count, bit squeeze, bit settle);
        int sent;
        int burst;
        int k;
        bit squeezed;
        bit settled;
        sent     = 0;
        squeezed = 1'b0;
        settled  = 1'b0;
        while (sent < count)
        begin
            if (squeeze && !squeezed && sent >= count / 3)
            begin
                squeezed = 1'b1;
                hold_requests++;
                for (k = 0; k < SQUEEZE_ITEMS; k++)
                begin
                    send_command(random_command());
                    sent++;
                end
            end
            if (settle && !settled && sent >= count / 2)
            begin
                settled = 1'b1;
                drain_results();
            end
            burst = $urandom_range(1, BURST_MAX);
            for (k = 0; k < burst && sent < count; k++)
            begin
                send_command(random_command());
                sent++;
            end
            pause_sender($urandom_range(0, 7));
        end
    endtask

    initial
    begin
        int i;
        int phase;
        book = new();
        hold_requests    = 0;
        settings_applied = 0;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        cmd_ch.valid              <= 1'b0;
        cmd_ch.command_irq_enable <= 1'b0;
        cmd_ch.event_irq_enable   <= 1'b0;
        cmd_ch.audio_ready        <= 1'b0;
        cmd_ch.audio_size         <= '0;
        cmd_ch.video_ready        <= 1'b0;
        cmd_ch.video_size         <= '0;
        cmd_ch.motion_on          <= 1'b0;
        cmd_ch.motion_count       <= '0;
        cmd_ch.jpeg_ready         <= 1'b0;
        cmd_ch.jpeg_size          <= '0;
        cmd_ch.host_accepts       <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items under the reset register values
        send_command(build_command(1'b0, 1'b0, 4'b1111, 24'h123456, 1'b1));
        send_command(build_command(1'b1, 1'b0, 4'b1111, 24'h654321, 1'b1));
        send_command(build_command(1'b1, 1'b1, 4'b0000, 24'h123456, 1'b1));
        send_command(build_command(1'b0, 1'b1, 4'b1111, 24'hFFFFFF, 1'b0));
        for (i = 0; i < SRC_IN; i++)
            send_command(build_command(1'b1, 1'b1, SRC_IN'(1 << i), 24'hFFFFFF, 1'b1));
        // Motion switched on with a zero count is not eligible
        send_command(build_command(1'b1, 1'b1, 4'b0100, 24'h000000, 1'b1));
        // Everyone asking: ties and weighting
        for (i = 0; i < 8; i++)
            send_command(build_command(1'b1, 1'b1, 4'b1111, 24'h000000, 1'b1));
        drain_results();

        // Period of one, and a motion weight with the upper data bits set
        apply_setting(6'd0, 6'd15, 6'h3F, 6'd7, 6'd1);
        for (i = 0; i < 4; i++)
            send_command(build_command(1'b1, 1'b1, 4'b1111, 24'hABCDEF, 1'b1));
        drain_results();

        // Unmapped index is ignored; a zero period clears on every command
        write_register(CFG_UNMAPPED, '1);
        apply_setting(6'd1, 6'd1, 6'd1, 6'd1, 6'd0);
        for (i = 0; i < 3; i++)
            send_command(build_command(1'b0, 1'b1, 4'b1111, 24'h800000, 1'b1));
        drain_results();

        // Random phases, one register setting each
        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: apply_setting(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                                 CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                                 CFG_DATA_W'($urandom_range(1, 63)));
                1: apply_setting(6'd0, 6'd0, 6'd0, 6'd0, 6'd63);
                2: apply_setting(6'd15, 6'd15, 6'd15, 6'd15, 6'd63);
                3: apply_setting(6'd15, 6'd1, 6'd15, 6'd1, 6'd1);
                4: apply_setting(CFG_DATA_W'($urandom_range(0, 15)),
                                 CFG_DATA_W'($urandom_range(0, 15)),
                                 CFG_DATA_W'($urandom_range(0, 15)),
                                 CFG_DATA_W'($urandom_range(0, 15)),
                                 CFG_DATA_W'($urandom_range(0, 63)));
                default: apply_setting(CFG_DATA_W'(RST_WEIGHT_AUDIO),
                                       CFG_DATA_W'(RST_WEIGHT_OTHER),
                                       CFG_DATA_W'(RST_WEIGHT_OTHER),
                                       CFG_DATA_W'(RST_WEIGHT_OTHER),
                                       CFG_DATA_W'(RST_PERIOD));
            endcase
            run_phase(PHASE_ITEMS, phase == 2, phase == 3);
            drain_results();
        end

        repeat (8) @(posedge clk);
        $display("Covered %0d commands, %0d interrupts raised, across %0d register settings",
                 book.commands, book.raises, settings_applied);
        $display("Included a long interrupt-side stall and a mid-phase drain of all results");
        if (book.errors == 0 && book.pending_grants.size() == 0)
            $display("weighted_interrupt_arbiter verification clean");
        else
            $display("weighted_interrupt_arbiter verification failed");
        $finish;
    end

endmodule
